/* sv/abs_pkg.sv */
// Shared types and constants of the alternating-bit sender.
package abs_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 20;
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;

  typedef enum logic [1:0] {
    CMD_MSG_BYTE = 2'd0,
    CMD_ACK_BYTE = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PKT_BYTE    = 3'd0,
    KIND_ACK_OK      = 3'd1,
    KIND_ACK_CORRUPT = 3'd2,
    KIND_ACK_IGNORED = 3'd3,
    KIND_MSG_REFUSED = 3'd4
  } kind_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  data_byte;
    logic [7:0]  pkt_seq;
    logic [7:0]  pkt_ack;
    logic [15:0] pkt_checksum;
    logic        last;
  } in_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        out_seq;
    logic        out_ack;
    logic [15:0] out_checksum;
    logic        end_of_run;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

/* sv/abs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module abs_ram #(
  parameter int unsigned Width     = 8,
  parameter int unsigned Depth     = 20,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/alternating_bit_sender.sv */
// Top level of the alternating-bit sender: collector, ack checker, timer, packet emitter.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   request | in        | in_valid_i / in_stall_o | in_req_i  (in_req_t)
//   result  | out       | out_valid_o/ out_stall_i| out_rsp_o (out_rsp_t)
//   config  | in        | cfg_we_i                | cfg_wdata_i (timeout)
//
// Message bytes, ack bytes and ticks are each accepted in ST_IDLE when the result register is free.
// A short message first zeroes each unfilled payload position of the store in ST_FILL.
// A packet run streams PayloadBytes bytes from the payload RAM, one per cycle while the result
// is not stalled, through its registered read port; no request is taken during the run.
// Reset clears all control state; the payload RAM is not cleared.
// A stalled result holds the result register and stalls the request side.
module alternating_bit_sender #(
  parameter int unsigned PayloadBytes = abs_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  abs_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output abs_pkg::out_rsp_t out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);
  import abs_pkg::*;

  localparam int unsigned AddrW = (PayloadBytes > 1) ? $clog2(PayloadBytes) : 1;
  localparam int unsigned CntW  = $clog2(PayloadBytes + 1);
  localparam logic [CntW-1:0] PCount  = CntW'(PayloadBytes);
  localparam logic [CntW-1:0] LastIdx = CntW'(PayloadBytes - 1);

  state_e         state_q, state_d;
  logic [15:0]    timeout_q, timeout_d;
  logic           busy_q, busy_d;
  logic           next_bit_q, next_bit_d;
  logic           sent_bit_q, sent_bit_d;
  logic [15:0]    sent_sum_q, sent_sum_d;
  logic [15:0]    countdown_q, countdown_d;
  logic [CntW-1:0] load_idx_q, load_idx_d;
  logic [15:0]    msg_sum_q, msg_sum_d;
  logic           refusing_q, refusing_d;
  logic [15:0]    ack_sum_q, ack_sum_d;
  logic [CntW-1:0] issue_idx_q, issue_idx_d;
  logic           pend_q, pend_d;
  logic           pend_last_q, pend_last_d;
  logic           out_valid_q, out_valid_d;
  out_rsp_t       out_q, out_d;

  logic           accept, out_free, move, rd_en;
  logic           ram_we;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           refusing_new, store_en;
  logic [CntW-1:0] li_new;
  logic [15:0]    msum_new, ack_sum_new, ack_calc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign refusing_new = refusing_q || busy_q;
  assign store_en     = !refusing_new && (load_idx_q < PCount);
  assign li_new       = load_idx_q + CntW'(store_en);
  assign msum_new     = msg_sum_q + (store_en ? {8'd0, in_req_i.data_byte} : 16'd0);
  assign ack_sum_new  = ack_sum_q + {8'd0, in_req_i.data_byte};
  assign ack_calc     = ack_sum_new + {8'd0, in_req_i.pkt_seq} + {8'd0, in_req_i.pkt_ack};

  assign move  = (state_q == ST_EMIT) && pend_q && out_free;
  assign rd_en = (state_q == ST_EMIT) && (issue_idx_q != PCount) && (!pend_q || move);

  assign ram_we = (state_q == ST_FILL) ||
                  (accept && (in_req_i.command == CMD_MSG_BYTE) && store_en);
  assign ram_wdata = (state_q == ST_FILL) ? 8'd0 : in_req_i.data_byte;

  abs_ram #(
    .Width(8),
    .Depth(PayloadBytes)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(load_idx_q[AddrW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(issue_idx_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    timeout_d   = cfg_we_i ? cfg_wdata_i : timeout_q;
    busy_d      = busy_q;
    next_bit_d  = next_bit_q;
    sent_bit_d  = sent_bit_q;
    sent_sum_d  = sent_sum_q;
    countdown_d = countdown_q;
    load_idx_d  = load_idx_q;
    msg_sum_d   = msg_sum_q;
    refusing_d  = refusing_q;
    ack_sum_d   = ack_sum_q;
    issue_idx_d = issue_idx_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d = '{kind: KIND_PKT_BYTE, out_byte: 8'd0, out_seq: 1'b0, out_ack: 1'b0,
                    out_checksum: 16'd0, end_of_run: 1'b0};
          unique case (in_req_i.command)
            CMD_MSG_BYTE: begin
              refusing_d = refusing_new;
              load_idx_d = li_new;
              msg_sum_d  = msum_new;
              if (in_req_i.last) begin
                msg_sum_d = 16'd0;
                if (refusing_new) begin
                  refusing_d  = 1'b0;
                  load_idx_d  = '0;
                  out_valid_d = 1'b1;
                  out_d.kind  = KIND_MSG_REFUSED;
                end else begin
                  sent_bit_d  = next_bit_q;
                  sent_sum_d  = msum_new + {14'd0, next_bit_q, 1'b0};
                  next_bit_d  = !next_bit_q;
                  busy_d      = 1'b1;
                  countdown_d = timeout_q;
                  issue_idx_d = '0;
                  pend_d      = 1'b0;
                  pend_last_d = 1'b0;
                  if (li_new < PCount) begin
                    state_d = ST_FILL;
                  end else begin
                    load_idx_d = '0;
                    state_d    = ST_EMIT;
                  end
                end
              end
            end
            CMD_ACK_BYTE: begin
              ack_sum_d = ack_sum_new;
              if (in_req_i.last) begin
                ack_sum_d   = 16'd0;
                out_valid_d = 1'b1;
                priority if (!busy_q) begin
                  out_d.kind = KIND_ACK_IGNORED;
                end else if (in_req_i.pkt_checksum != ack_calc) begin
                  out_d.kind = KIND_ACK_CORRUPT;
                end else if (in_req_i.pkt_ack == {7'd0, sent_bit_q}) begin
                  busy_d      = 1'b0;
                  countdown_d = 16'd0;
                  out_d.kind  = KIND_ACK_OK;
                end else begin
                  out_d.kind = KIND_ACK_IGNORED;
                end
              end
            end
            CMD_TICK: begin
              if (busy_q) begin
                if (countdown_q <= 16'd1) begin
                  countdown_d = timeout_q;
                  issue_idx_d = '0;
                  pend_d      = 1'b0;
                  pend_last_d = 1'b0;
                  state_d     = ST_EMIT;
                end else begin
                  countdown_d = countdown_q - 16'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        if (load_idx_q == LastIdx) begin
          load_idx_d = '0;
          state_d    = ST_EMIT;
        end else begin
          load_idx_d = load_idx_q + CntW'(1);
        end
      end
      ST_EMIT: begin
        if (rd_en) begin
          issue_idx_d = issue_idx_q + CntW'(1);
          pend_last_d = (issue_idx_q == LastIdx);
        end
        pend_d = rd_en || (pend_q && !move);
        if (move) begin
          out_valid_d = 1'b1;
          out_d = '{kind: KIND_PKT_BYTE, out_byte: ram_rdata, out_seq: sent_bit_q,
                    out_ack: sent_bit_q, out_checksum: sent_sum_q, end_of_run: pend_last_q};
          if (pend_last_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TIMEOUT_RESET;
      busy_q      <= 1'b0;
      next_bit_q  <= 1'b0;
      sent_bit_q  <= 1'b0;
      sent_sum_q  <= 16'd0;
      countdown_q <= 16'd0;
      load_idx_q  <= '0;
      msg_sum_q   <= 16'd0;
      refusing_q  <= 1'b0;
      ack_sum_q   <= 16'd0;
      issue_idx_q <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      timeout_q   <= timeout_d;
      busy_q      <= busy_d;
      next_bit_q  <= next_bit_d;
      sent_bit_q  <= sent_bit_d;
      sent_sum_q  <= sent_sum_d;
      countdown_q <= countdown_d;
      load_idx_q  <= load_idx_d;
      msg_sum_q   <= msg_sum_d;
      refusing_q  <= refusing_d;
      ack_sum_q   <= ack_sum_d;
      issue_idx_q <= issue_idx_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A packet run only happens while a packet is outstanding.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> busy_q)
    else $error("packet run while not busy");

  // The zero fill never walks past the end of the payload store.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (load_idx_q < PCount))
    else $error("fill index out of range");

  // A pending read always belongs to an address already issued.
  a_pend_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (issue_idx_q != '0))
    else $error("pending read without issued address");

  // Only packet bytes may mark the end of a run.
  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.end_of_run) |-> (out_q.kind == KIND_PKT_BYTE))
    else $error("end of run on a status result");

  // Leaving a run back to idle happens exactly on its final byte.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && (state_d == ST_IDLE)) |=> (out_valid_q && out_q.end_of_run))
    else $error("run ended without final byte");

endmodule
